>>> hdl/i2cm_pkg.sv
// Shared types, constants and helpers for the I2C master bit sequencer.
package i2cm_pkg;

  localparam int TIMER_BITS = 8;
  localparam int TMAX       = (1 << TIMER_BITS) - 1;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_START_STOP = 2'd0,
    REG_BIT_LOW    = 2'd1,
    REG_BIT_HIGH   = 2'd2,
    REG_ACK_TMO    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
    PH_W_LOW, PH_W_HIGH, PH_A_LOW, PH_A_POLL,
    PH_R_LOW, PH_R_HIGH, PH_M_LOW, PH_M_HIGH
  } phase_t;

  localparam logic [7:0] START_STOP_RST = 8'd4;
  localparam logic [7:0] BIT_LOW_RST    = 8'd2;
  localparam logic [7:0] BIT_HIGH_RST   = 8'd6;
  localparam logic [7:0] ACK_TMO_RST    = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

  typedef struct packed {
    logic [7:0] start_stop_ticks;
    logic [7:0] bit_low_ticks;
    logic [7:0] bit_high_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic [7:0] read_data;
    logic       nack_seen;
    logic       done_res;
  } res_t;

  // Phase length: zero acts as one, long values saturate at the timer range.
  function automatic timer_t span(input logic [7:0] r);
    timer_t d;
    if (r == 8'd0) begin
      d = timer_t'(1);
    end else if (int'(r) > TMAX) begin
      d = timer_t'(TMAX);
    end else begin
      d = timer_t'(r);
    end
    return d;
  endfunction

endpackage

>>> hdl/i2cm_if.sv
// Valid/ready channel interfaces for the request and result streams.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] write_data;
  logic       send_ack;
  logic       sda_sample;

  modport source (output valid, cmd, write_data, send_ack, sda_sample, input ready);
  modport sink   (input valid, cmd, write_data, send_ack, sda_sample, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic [7:0] read_data;
  logic       nack_seen;
  logic       done_res;

  modport source (output valid, scl_level, sda_level, busy_res, read_data, nack_seen,
                  done_res, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, read_data, nack_seen,
                  done_res, output ready);
endinterface

>>> hdl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: config registers, handshake, result register.
//
// Usage: every request on in_chan is one tick of the bus timebase. It carries a
// command (start, write byte, read byte, stop; honored only while idle), the byte
// to write, the ACK choice for a read and the SDA level sampled on that tick.
// Every request yields exactly one result on out_chan: the SCL/SDA drive levels
// after the tick (1 = released), busy, the last received byte, the NACK flag of
// the last write and a one-tick done pulse.
// A request accepted at an edge shows its result from the next cycle on. Throughput
// is one request per cycle while the receiver takes results; the whole tick update is
// one pass of next-state logic between the sequencer state and the result register.
// in_chan.ready stays high while the result register is empty or being drained, so
// a stalled receiver holds the pending result and stalls the request side after it.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// Synchronous active-low reset returns to idle with both lines released, clears
// the flags and restores the default timing registers.
module i2c_master_bit_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  i2cm_in_if.sink              in_chan,
  i2cm_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  i2cm_pkg::cfg_idx_t   cfg_index,
  input  logic [7:0]           cfg_wdata
);
  import i2cm_pkg::*;

  cfg_t cfg_r;
  req_t req;
  res_t res;
  res_t out_data_r;
  logic out_valid_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_stop_ticks <= START_STOP_RST;
      cfg_r.bit_low_ticks    <= BIT_LOW_RST;
      cfg_r.bit_high_ticks   <= BIT_HIGH_RST;
      cfg_r.ack_timeout      <= ACK_TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_STOP: cfg_r.start_stop_ticks <= cfg_wdata;
        REG_BIT_LOW:    cfg_r.bit_low_ticks    <= cfg_wdata;
        REG_BIT_HIGH:   cfg_r.bit_high_ticks   <= cfg_wdata;
        REG_ACK_TMO:    cfg_r.ack_timeout      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign req.cmd        = in_chan.cmd;
  assign req.write_data = in_chan.write_data;
  assign req.send_ack   = in_chan.send_ack;
  assign req.sda_sample = in_chan.sda_sample;

  i2cm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (accept),
    .cfg   (cfg_r),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.scl_level = out_data_r.scl_level;
  assign out_chan.sda_level = out_data_r.sda_level;
  assign out_chan.busy_res  = out_data_r.busy_res;
  assign out_chan.read_data = out_data_r.read_data;
  assign out_chan.nack_seen = out_data_r.nack_seen;
  assign out_chan.done_res  = out_data_r.done_res;

endmodule

>>> hdl/i2cm_core.sv
// Bus phase sequencer: state registers and next-state logic for one tick.
module i2cm_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  i2cm_pkg::cfg_t cfg,
  input  i2cm_pkg::req_t req,
  output i2cm_pkg::res_t res
);
  import i2cm_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_r, shift_nxt;
  timer_t     tick_count_r, tick_count_nxt;
  logic [7:0] poll_count_r, poll_count_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic       nack_r, nack_nxt;
  logic       done;
  timer_t     dur;
  timer_t     tick_inc;
  logic [7:0] poll_inc;
  logic [7:0] shift_sh;
  logic [3:0] bit_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_count_r  <= '0;
      shift_r      <= '0;
      tick_count_r <= '0;
      poll_count_r <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      rx_byte_r    <= '0;
      nack_r       <= 1'b0;
    end else if (en) begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      tick_count_r <= tick_count_nxt;
      poll_count_r <= poll_count_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      rx_byte_r    <= rx_byte_nxt;
      nack_r       <= nack_nxt;
    end
  end

  always_comb begin
    case (phase_r)
      PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B:       dur = span(cfg.start_stop_ticks);
      PH_W_LOW, PH_A_LOW, PH_R_LOW, PH_M_LOW:   dur = span(cfg.bit_low_ticks);
      PH_W_HIGH, PH_R_HIGH, PH_M_HIGH:          dur = span(cfg.bit_high_ticks);
      default:                                  dur = timer_t'(1);
    endcase
  end

  assign tick_inc = tick_count_r + timer_t'(1);
  assign poll_inc = poll_count_r + 8'd1;
  assign bit_inc  = bit_count_r + 4'd1;
  assign shift_sh = (phase_r == PH_R_HIGH) ? {shift_r[6:0], req.sda_sample}
                                           : {shift_r[6:0], 1'b0};

  always_comb begin
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    tick_count_nxt = tick_count_r;
    poll_count_nxt = poll_count_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    rx_byte_nxt    = rx_byte_r;
    nack_nxt       = nack_r;
    done           = 1'b0;

    if (phase_r == PH_IDLE) begin
      case (req.cmd)
        CMD_START: begin
          phase_nxt = PH_ST_A; scl_nxt = 1'b1; sda_nxt = 1'b1; tick_count_nxt = '0;
        end
        CMD_WRITE: begin
          shift_nxt = req.write_data; bit_count_nxt = '0;
          phase_nxt = PH_W_LOW; scl_nxt = 1'b0; sda_nxt = req.write_data[7];
          tick_count_nxt = '0;
        end
        CMD_READ: begin
          shift_nxt = '0; bit_count_nxt = '0; ack_choice_nxt = req.send_ack;
          phase_nxt = PH_R_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1; tick_count_nxt = '0;
        end
        CMD_STOP: begin
          phase_nxt = PH_SP_A; scl_nxt = 1'b0; sda_nxt = 1'b0; tick_count_nxt = '0;
        end
        default: ;
      endcase
    end else if (phase_r == PH_A_POLL) begin
      if (!req.sda_sample) begin
        nack_nxt = 1'b0; done = 1'b1;
        phase_nxt = PH_IDLE; scl_nxt = 1'b0; tick_count_nxt = '0;
      end else begin
        poll_count_nxt = poll_inc;
        if (poll_inc >= cfg.ack_timeout) begin
          // no ACK in time: flag it and release the bus with a stop
          nack_nxt = 1'b1;
          phase_nxt = PH_SP_A; scl_nxt = 1'b0; sda_nxt = 1'b0; tick_count_nxt = '0;
        end
      end
    end else begin
      tick_count_nxt = tick_inc;
      if (tick_inc >= dur) begin
        tick_count_nxt = '0;
        case (phase_r)
          PH_ST_A: begin phase_nxt = PH_ST_B; scl_nxt = 1'b1; sda_nxt = 1'b0; end
          PH_ST_B: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; sda_nxt = 1'b0; done = 1'b1;
          end
          PH_SP_A: begin phase_nxt = PH_SP_B; scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_SP_B: begin
            phase_nxt = PH_IDLE; scl_nxt = 1'b1; sda_nxt = 1'b1; done = 1'b1;
          end
          PH_W_LOW: begin phase_nxt = PH_W_HIGH; scl_nxt = 1'b1; end
          PH_W_HIGH: begin
            shift_nxt = shift_sh; bit_count_nxt = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_nxt = PH_W_LOW; scl_nxt = 1'b0; sda_nxt = shift_sh[7];
            end else begin
              phase_nxt = PH_A_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1;
            end
          end
          PH_A_LOW: begin
            poll_count_nxt = '0;
            phase_nxt = PH_A_POLL; scl_nxt = 1'b1; sda_nxt = 1'b1;
          end
          PH_R_LOW: begin phase_nxt = PH_R_HIGH; scl_nxt = 1'b1; sda_nxt = 1'b1; end
          PH_R_HIGH: begin
            // data bit taken on the last tick of SCL high
            shift_nxt = shift_sh; bit_count_nxt = bit_inc;
            if (bit_inc < BITS_PER_BYTE) begin
              phase_nxt = PH_R_LOW; scl_nxt = 1'b0; sda_nxt = 1'b1;
            end else begin
              phase_nxt = PH_M_LOW; scl_nxt = 1'b0; sda_nxt = !ack_choice_r;
            end
          end
          PH_M_LOW: begin phase_nxt = PH_M_HIGH; scl_nxt = 1'b1; end
          PH_M_HIGH: begin
            rx_byte_nxt = shift_r;
            phase_nxt = PH_IDLE; scl_nxt = 1'b0; done = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  assign res.scl_level = scl_nxt;
  assign res.sda_level = sda_nxt;
  assign res.busy_res  = (phase_nxt != PH_IDLE);
  assign res.read_data = rx_byte_nxt;
  assign res.nack_seen = nack_nxt;
  assign res.done_res  = done;

`ifndef SYNTHESIS
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    en && done |=> phase_r == PH_IDLE)
    else $error("completion did not return to idle");
  a_bit_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= BITS_PER_BYTE)
    else $error("bit counter past one byte");
  a_poll_released: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_A_POLL |-> scl_r && sda_r)
    else $error("bus not released while polling for ACK");
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_count_r == '0)
    else $error("phase timer not cleared in idle");
`endif

endmodule

>>> bench/i2cm_bus_checker.sv
// Checker for the I2C master bit sequencer: tracks bus state per tick and checks every result.
module i2cm_bus_checker import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  i2cm_in_if         in_chan,
  i2cm_out_if        out_chan,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         mismatches,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t       timing;
  phase_t     ph;
  logic [3:0] bits_done;
  logic [7:0] shifter;
  logic [7:0] tick_cnt;
  logic [7:0] poll_cnt;
  logic [7:0] rx_byte;
  logic       ack_pick;
  logic       scl_drv;
  logic       sda_drv;
  logic       nack_flag;
  res_t       bus_levels_q[$];
  int         result_no;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_no, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic move_to(input phase_t p, input logic scl, input logic sda);
    ph       = p;
    scl_drv  = scl;
    sda_drv  = sda;
    tick_cnt = '0;
  endtask

  // One bus tick: returns the drive levels and flags after the tick.
  task automatic advance_bus_tick(input logic [2:0] cmd, input logic [7:0] wdata,
                                  input logic sack, input logic sda_in, output res_t r);
    logic [7:0] span_len;
    logic       done;
    done = 1'b0;
    case (ph)
      PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B:     span_len = timing.start_stop_ticks;
      PH_W_LOW, PH_A_LOW, PH_R_LOW, PH_M_LOW: span_len = timing.bit_low_ticks;
      PH_W_HIGH, PH_R_HIGH, PH_M_HIGH:        span_len = timing.bit_high_ticks;
      default:                                span_len = 8'd1;
    endcase
    // a zero register still gives a one-tick phase
    if (span_len == 8'd0) span_len = 8'd1;

    if (ph == PH_IDLE) begin
      case (cmd)
        CMD_START: move_to(PH_ST_A, 1'b1, 1'b1);
        CMD_WRITE: begin
          shifter   = wdata;
          bits_done = '0;
          move_to(PH_W_LOW, 1'b0, wdata[7]);
        end
        CMD_READ: begin
          shifter   = '0;
          bits_done = '0;
          ack_pick  = sack;
          move_to(PH_R_LOW, 1'b0, 1'b1);
        end
        CMD_STOP: move_to(PH_SP_A, 1'b0, 1'b0);
        default: ;
      endcase
    end else if (ph == PH_A_POLL) begin
      if (!sda_in) begin
        nack_flag = 1'b0;
        done      = 1'b1;
        move_to(PH_IDLE, 1'b0, sda_drv);
      end else begin
        poll_cnt = poll_cnt + 8'd1;
        if (poll_cnt >= timing.ack_timeout) begin
          nack_flag = 1'b1;
          move_to(PH_SP_A, 1'b0, 1'b0);
        end
      end
    end else begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= span_len) begin
        case (ph)
          PH_ST_A: move_to(PH_ST_B, 1'b1, 1'b0);
          PH_ST_B: begin
            move_to(PH_IDLE, 1'b0, 1'b0);
            done = 1'b1;
          end
          PH_SP_A: move_to(PH_SP_B, 1'b1, 1'b1);
          PH_SP_B: begin
            move_to(PH_IDLE, 1'b1, 1'b1);
            done = 1'b1;
          end
          PH_W_LOW: move_to(PH_W_HIGH, 1'b1, sda_drv);
          PH_W_HIGH: begin
            shifter   = shifter << 1;
            bits_done = bits_done + 4'd1;
            if (bits_done < BITS_PER_BYTE) move_to(PH_W_LOW, 1'b0, shifter[7]);
            else move_to(PH_A_LOW, 1'b0, 1'b1);
          end
          PH_A_LOW: begin
            poll_cnt = '0;
            move_to(PH_A_POLL, 1'b1, 1'b1);
          end
          PH_R_LOW: move_to(PH_R_HIGH, 1'b1, 1'b1);
          PH_R_HIGH: begin
            shifter   = {shifter[6:0], sda_in};
            bits_done = bits_done + 4'd1;
            if (bits_done < BITS_PER_BYTE) move_to(PH_R_LOW, 1'b0, 1'b1);
            else move_to(PH_M_LOW, 1'b0, !ack_pick);
          end
          PH_M_LOW: move_to(PH_M_HIGH, 1'b1, sda_drv);
          PH_M_HIGH: begin
            rx_byte = shifter;
            move_to(PH_IDLE, 1'b0, sda_drv);
            done = 1'b1;
          end
          default: move_to(PH_IDLE, scl_drv, sda_drv);
        endcase
      end
    end

    r.scl_level = scl_drv;
    r.sda_level = sda_drv;
    r.busy_res  = (ph != PH_IDLE);
    r.read_data = rx_byte;
    r.nack_seen = nack_flag;
    r.done_res  = done;
  endtask

  always @(posedge clk) begin : track
    res_t want;
    if (!rst_n) begin
      timing    = '{START_STOP_RST, BIT_LOW_RST, BIT_HIGH_RST, ACK_TMO_RST};
      ph        = PH_IDLE;
      bits_done = '0;
      shifter   = '0;
      tick_cnt  = '0;
      poll_cnt  = '0;
      rx_byte   = '0;
      ack_pick  = 1'b0;
      scl_drv   = 1'b1;
      sda_drv   = 1'b1;
      nack_flag = 1'b0;
      bus_levels_q.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        result_no++;
        if (bus_levels_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = bus_levels_q.pop_front();
          compare_field("scl_level", 8'(out_chan.scl_level), 8'(want.scl_level));
          compare_field("sda_level", 8'(out_chan.sda_level), 8'(want.sda_level));
          compare_field("busy_res", 8'(out_chan.busy_res), 8'(want.busy_res));
          compare_field("read_data", out_chan.read_data, want.read_data);
          compare_field("nack_seen", 8'(out_chan.nack_seen), 8'(want.nack_seen));
          compare_field("done_res", 8'(out_chan.done_res), 8'(want.done_res));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_STOP: timing.start_stop_ticks = cfg_wdata;
          REG_BIT_LOW:    timing.bit_low_ticks    = cfg_wdata;
          REG_BIT_HIGH:   timing.bit_high_ticks   = cfg_wdata;
          REG_ACK_TMO:    timing.ack_timeout      = cfg_wdata;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        advance_bus_tick(in_chan.cmd, in_chan.write_data, in_chan.send_ack,
                         in_chan.sda_sample, want);
        bus_levels_q.push_back(want);
      end
    end
    pending = bus_levels_q.size();
  end

endmodule

>>> bench/tb_i2c_master_bit_sequencer.sv
// Testbench top for the I2C master bit sequencer: clock, reset, stimulus and verdict.
module tb_i2c_master_bit_sequencer import i2cm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STUCK_LIMIT     = 1000;
  localparam int         RAND_PHASES     = 5;
  localparam int         TICKS_PER_PHASE = 40;
  localparam logic [2:0] CMD_UNDEF_LO    = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI    = 3'd7;

  // how the modeled slave drives SDA back to the master
  typedef enum logic [1:0] {SDA_COIN, SDA_HIGH, SDA_RARE_LOW, SDA_LOW} sda_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  logic [7:0] cfg_wdata;
  int         mismatches;
  int         pending;

  sda_mode_t  slave_sda = SDA_COIN;
  logic       quiet = 1'b0;
  int         ticks_sent;
  int         results_seen;
  int         last_idle_tick;
  int         stuck_cycles;
  int         settings_used;
  int         cmd_count[8];

  i2cm_in_if  in_chan();
  i2cm_out_if out_chan();

  i2c_master_bit_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  i2cm_bus_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (rst_n) out_chan.ready <= quiet || ($urandom_range(99) >= 6);
  end

  // result bookkeeping for the stimulus side, plus the stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (!out_chan.busy_res) last_idle_tick = results_seen;
    end
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no handshake for %0d cycles", STUCK_LIMIT);
        $display("tb_i2c_master_bit_sequencer: FAIL");
        $finish;
      end
    end
  end

  // Called and returns at a falling edge; valid stays high after the request goes.
  task automatic send_tick(input logic [2:0] c, input logic [7:0] wd, input logic sack);
    logic sda;
    while (!quiet && $urandom_range(99) < 6) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    case (slave_sda)
      SDA_COIN:     sda = 1'($urandom_range(1));
      SDA_HIGH:     sda = 1'b1;
      SDA_RARE_LOW: sda = ($urandom_range(7) != 0);
      default:      sda = 1'b0;
    endcase
    in_chan.valid      <= 1'b1;
    in_chan.cmd        <= c;
    in_chan.write_data <= wd;
    in_chan.send_ack   <= sack;
    in_chan.sda_sample <= sda;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Plain ticks until a result at or after tick idx shows the sequencer idle.
  task automatic run_until_idle(input int idx);
    while (last_idle_tick < idx) send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
  endtask

  task automatic issue(input cmd_t c, input logic [7:0] wd, input logic sack);
    send_tick(c, wd, sack);
    cmd_count[c]++;
    run_until_idle(ticks_sent);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (results_seen < ticks_sent);
  endtask

  task automatic load_timing(input logic [7:0] ss, input logic [7:0] lo,
                             input logic [7:0] hi, input logic [7:0] tmo);
    cfg_idx_t   regs[4];
    logic [7:0] vals[4];
    regs = '{REG_START_STOP, REG_BIT_LOW, REG_BIT_HIGH, REG_ACK_TMO};
    vals = '{ss, lo, hi, tmo};
    drain_results();
    repeat (2) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // start, a few writes, maybe a repeated start and reads, stop
  task automatic random_transaction();
    int n;
    int pick;
    slave_sda = SDA_COIN;
    issue(CMD_START, 8'($urandom), 1'($urandom));
    n = $urandom_range(3, 1);
    repeat (n) begin
      pick = $urandom_range(9);
      slave_sda = (pick < 6) ? SDA_RARE_LOW : (pick < 8) ? SDA_COIN : SDA_HIGH;
      issue(CMD_WRITE, 8'($urandom), 1'($urandom));
    end
    slave_sda = SDA_COIN;
    if ($urandom_range(1)) begin
      if ($urandom_range(1)) issue(CMD_START, 8'($urandom), 1'($urandom));
      n = $urandom_range(2, 1);
      repeat (n) issue(CMD_READ, 8'($urandom), 1'($urandom));
    end
    issue(CMD_STOP, 8'($urandom), 1'($urandom));
  endtask

  task automatic noise_burst();
    int k;
    slave_sda = SDA_COIN;
    k = $urandom_range(6, 1);
    repeat (k) send_tick(3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom));
    run_until_idle(ticks_sent);
  endtask

  initial begin
    int budget;
    int roll;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_START_STOP;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.cmd        = CMD_NONE;
    in_chan.write_data = '0;
    in_chan.send_ack   = 1'b0;
    in_chan.sda_sample = 1'b1;
    out_chan.ready     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default timing after reset
    issue(CMD_START, 8'h00, 1'b0);
    slave_sda = SDA_LOW;
    issue(CMD_WRITE, 8'hFF, 1'b0);
    slave_sda = SDA_HIGH;                       // no ACK: timeout, automatic stop
    issue(CMD_WRITE, 8'h00, 1'b1);
    issue(CMD_START, 8'hFF, 1'b1);
    slave_sda = SDA_RARE_LOW;
    send_tick(CMD_WRITE, 8'h5A, 1'b0);
    send_tick(CMD_START, 8'hA5, 1'b1);          // ignored, sequencer busy
    run_until_idle(ticks_sent - 1);
    slave_sda = SDA_COIN;
    issue(CMD_READ, 8'h00, 1'b1);
    issue(CMD_READ, 8'hFF, 1'b0);
    issue(CMD_READ, 8'h3C, 1'b1);               // SDA held low after master ACK
    issue(CMD_STOP, 8'h00, 1'b0);
    for (int u = CMD_UNDEF_LO; u <= CMD_UNDEF_HI; u++) send_tick(3'(u), 8'hFF, 1'b1);
    send_tick(CMD_NONE, 8'h00, 1'b0);
    drain_results();
    issue(CMD_STOP, 8'h00, 1'b0);               // stop with no transfer open

    // zero registers: one-tick phases, immediate NACK
    load_timing(8'd0, 8'd0, 8'd0, 8'd0);
    issue(CMD_START, 8'h00, 1'b0);
    slave_sda = SDA_HIGH;
    issue(CMD_WRITE, 8'hA5, 1'b0);
    slave_sda = SDA_LOW;
    issue(CMD_WRITE, 8'h81, 1'b0);
    slave_sda = SDA_COIN;
    issue(CMD_READ, 8'h00, 1'b1);
    issue(CMD_READ, 8'h00, 1'b0);
    issue(CMD_STOP, 8'h00, 1'b0);

    // full-scale timing: a lone stop runs both halves to the top of the timer
    load_timing(8'd255, 8'd255, 8'd255, 8'd255);
    issue(CMD_STOP, 8'h00, 1'b0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: load_timing(8'd1, 8'd1, 8'd1, 8'd1);
        1: load_timing(8'd2, 8'd1, 8'd3, 8'd5);
        2: load_timing(START_STOP_RST, BIT_LOW_RST, BIT_HIGH_RST, ACK_TMO_RST);
        3: load_timing(8'($urandom_range(3)), 8'($urandom_range(3)),
                       8'($urandom_range(3)), 8'($urandom_range(3)));
        default: load_timing(8'($urandom_range(8, 1)), 8'($urandom_range(8, 1)),
                             8'($urandom_range(8, 1)), 8'($urandom_range(20, 1)));
      endcase
      quiet  = (p == 2);
      budget = ticks_sent + TICKS_PER_PHASE;
      while (ticks_sent < budget) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          random_transaction();
        end else if (roll < 85) begin
          noise_burst();
        end else if (roll < 95) begin
          slave_sda = sda_mode_t'($urandom_range(3));
          issue(cmd_t'($urandom_range(CMD_STOP, CMD_START)), 8'($urandom), 1'($urandom));
        end else begin
          drain_results();
        end
      end
      quiet = 1'b0;
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Ran %0d bus ticks over %0d timing settings, zero and full scale included;",
             ticks_sent, settings_used);
    $display("commands: %0d start, %0d write, %0d read, %0d stop, plus idle and undefined",
             cmd_count[CMD_START], cmd_count[CMD_WRITE], cmd_count[CMD_READ],
             cmd_count[CMD_STOP]);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_i2c_master_bit_sequencer: PASS");
    end else begin
      $display("tb_i2c_master_bit_sequencer: FAIL");
    end
    $finish;
  end

endmodule
